@@ rtl/impc_pkg.sv @@
// Shared types, field positions and saturating helpers for the impulse
// collision response block. Used by the csr, controller, datapath and top.
package impc_pkg;

   localparam int DEFAULT_FRACTION_BITS = 16;
   localparam int CFG_W = 17;

   // register indexes
   localparam logic REG_RESTITUTION = 1'b0;
   localparam logic REG_CORRECTION  = 1'b1;

   // stream payload layout
   localparam int REQ_TDATA_W = 264;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 192;

   localparam int REQ_PVX = 0;
   localparam int REQ_PVY = 32;
   localparam int REQ_CVX = 64;
   localparam int REQ_CVY = 96;
   localparam int REQ_IM  = 128;
   localparam int REQ_KND = 159;
   localparam int REQ_COL = 161;
   localparam int REQ_NX  = 162;
   localparam int REQ_NY  = 194;
   localparam int REQ_DEP = 226;

   // request selector codes
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_RESOLVE = 1'b1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_REL,
      OP_LDW,
      OP_DOTX,
      OP_DOTY,
      OP_DOTSUM,
      OP_CANX,
      OP_CANY,
      OP_CANW,
      OP_AMT,
      OP_SHX,
      OP_SHY,
      OP_SHW,
      OP_NUM,
      OP_DIVGO,
      OP_JSAT,
      OP_IX1,
      OP_IX2,
      OP_IY1,
      OP_IY2,
      OP_IW,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   body;
      logic   vec;
   } cmd_type;

   typedef struct packed {
      logic       is_load;
      logic       coll;
      logic       acc_pos;
      logic [1:0] fixd;
      logic [1:0] kin;
      logic       div_busy;
   } status_type;

   typedef struct packed {
      logic [CFG_W-1:0] restitution;
      logic [CFG_W-1:0] share;
   } cfg_type;

   localparam logic signed [65:0] S32_MAX_W = 66'sh7FFFFFFF;
   localparam logic signed [65:0] S32_MIN_W = -S32_MAX_W - 66'sd1;

   function automatic logic signed [65:0] sext(input logic [31:0] x);
      return $signed({{34{x[31]}}, x});
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX_W) r = 32'sh7FFFFFFF;
      else if (v < S32_MIN_W) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [32:0] s33(input logic [31:0] x);
      return $signed({x[31], x});
   endfunction

endpackage

@@ rtl/impc_csr.sv @@
// APB-style register bank: restitution and correction share.
// Depends on impc_pkg.
module impc_csr
   import impc_pkg::*;
#(
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);
   localparam logic [63:0] ONE_W = 64'd1 << FRACTION_BITS;
   localparam logic [63:0] REST_RST = (64'd8 * ONE_W + 64'd5) / 64'd10;
   localparam logic [63:0] SHARE_RST = (64'd2 * ONE_W + 64'd5) / 64'd10;

   logic [CFG_W-1:0] rest_ff;
   logic [CFG_W-1:0] share_ff;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   // write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff  <= REST_RST[CFG_W-1:0];
         share_ff <= SHARE_RST[CFG_W-1:0];
      end else if (wr_en) begin
         if (csr_paddr[2] == REG_RESTITUTION) rest_ff <= csr_pwdata[CFG_W-1:0];
         else share_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   // read back
   always_comb begin
      if (csr_paddr[2] == REG_RESTITUTION) csr_prdata = {15'd0, rest_ff};
      else csr_prdata = {15'd0, share_ff};
   end

   assign cfg.restitution = rest_ff;
   assign cfg.share       = share_ff;
endmodule

@@ rtl/impc_ctrl.sv @@
// Sequencer for load and resolve beats: issues at most one datapath op per cycle,
// holding while the divider is busy or a result is not taken. Depends on impc_pkg.
module impc_ctrl
   import impc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);
   typedef enum logic [5:0] {
      S_IDLE, S_DECODE, S_REL, S_DX, S_DY, S_DSUM, S_CHOOSE,
      S_CLDW, S_CDX, S_CDY, S_CDS, S_CCX, S_CCY, S_CCW,
      S_AMT, S_SHX, S_SHY, S_SHW,
      S_NUM, S_DIVGO, S_DIVW, S_JSAT,
      S_ISEL, S_IX1, S_IX2, S_IY1, S_IY2, S_IW,
      S_OUTA, S_WA, S_OUTB, S_WB
   } state_type;

   state_type state_ff, state_in;
   logic      body_ff, body_in;
   logic      vec_ff, vec_in;
   logic      dyn;

   assign dyn = ~status.fixd[body_ff] & ~status.kin[body_ff];

   always_comb begin
      state_in = state_ff;
      body_in  = body_ff;
      vec_in   = vec_ff;
      cmd.op   = OP_NONE;
      cmd.body = body_ff;
      cmd.vec  = vec_ff;
      case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_DECODE;
         S_DECODE: begin
            if (status.is_load) begin
               cmd.op = OP_LOAD;
               state_in = S_IDLE;
            end else if (status.coll) state_in = S_REL;
            else state_in = S_IDLE;
         end
         S_REL:  begin cmd.op = OP_REL;    state_in = S_DX; end
         S_DX:   begin cmd.op = OP_DOTX;   state_in = S_DY; end
         S_DY:   begin cmd.op = OP_DOTY;   state_in = S_DSUM; end
         S_DSUM: begin cmd.op = OP_DOTSUM; state_in = S_CHOOSE; end
         S_CHOOSE: begin
            vec_in = 1'b0;
            if (status.acc_pos) state_in = S_IDLE;
            else if (status.kin[0] && status.fixd[1]) begin
               body_in = 1'b0;
               state_in = S_CLDW;
            end else if (status.kin[1] && status.fixd[0]) begin
               body_in = 1'b1;
               state_in = S_CLDW;
            end else state_in = S_NUM;
         end
         // cancel the approaching component of one body's physical, then control vector
         S_CLDW: begin cmd.op = OP_LDW;    state_in = S_CDX; end
         S_CDX:  begin cmd.op = OP_DOTX;   state_in = S_CDY; end
         S_CDY:  begin cmd.op = OP_DOTY;   state_in = S_CDS; end
         S_CDS:  begin cmd.op = OP_DOTSUM; state_in = S_CCX; end
         S_CCX:  begin cmd.op = OP_CANX;   state_in = S_CCY; end
         S_CCY:  begin cmd.op = OP_CANY;   state_in = S_CCW; end
         S_CCW: begin
            cmd.op = OP_CANW;
            if (!vec_ff) begin
               vec_in = 1'b1;
               state_in = S_CLDW;
            end else if (!status.fixd[body_ff]) state_in = S_AMT;
            else state_in = S_OUTA;
         end
         // position shift
         S_AMT: begin cmd.op = OP_AMT; state_in = S_SHX; end
         S_SHX: begin cmd.op = OP_SHX; state_in = S_SHY; end
         S_SHY: begin cmd.op = OP_SHY; state_in = S_SHW; end
         S_SHW: begin cmd.op = OP_SHW; state_in = S_OUTA; end
         // impulse
         S_NUM:   begin cmd.op = OP_NUM;   state_in = S_DIVGO; end
         S_DIVGO: begin cmd.op = OP_DIVGO; state_in = S_DIVW; end
         S_DIVW:  if (!status.div_busy) state_in = S_JSAT;
         S_JSAT: begin
            cmd.op = OP_JSAT;
            body_in = 1'b0;
            state_in = S_ISEL;
         end
         S_ISEL: begin
            if (dyn) state_in = S_IX1;
            else if (!body_ff) body_in = 1'b1;
            else state_in = S_OUTA;
         end
         S_IX1: begin cmd.op = OP_IX1; state_in = S_IX2; end
         S_IX2: begin cmd.op = OP_IX2; state_in = S_IY1; end
         S_IY1: begin cmd.op = OP_IY1; state_in = S_IY2; end
         S_IY2: begin cmd.op = OP_IY2; state_in = S_IW; end
         S_IW: begin
            cmd.op = OP_IW;
            if (!body_ff) begin
               body_in = 1'b1;
               state_in = S_ISEL;
            end else state_in = S_OUTA;
         end
         // present A then B
         S_OUTA: begin
            cmd.op = OP_OUT;
            cmd.body = 1'b0;
            state_in = S_WA;
         end
         S_WA: if (rsp_tready) state_in = S_OUTB;
         S_OUTB: begin
            cmd.op = OP_OUT;
            cmd.body = 1'b1;
            state_in = S_WB;
         end
         S_WB: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         body_ff  <= 1'b0;
         vec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         body_ff  <= body_in;
         vec_ff   <= vec_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_WA) || (state_ff == S_WB);
endmodule

@@ rtl/impc_dp.sv @@
// Datapath: body state, one shared fixed-point multiplier, serial divider
// and output register. Depends on impc_pkg.
module impc_dp
   import impc_pkg::*;
#(
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  cfg_type                cfg,
   input  cmd_type                cmd,
   output status_type             status,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);
   localparam int DW = 32 + FRACTION_BITS;
   localparam int CNT_W = $clog2(DW + 1);
   localparam logic [32:0] FX_ONE = 33'd1 << FRACTION_BITS;

   // input beat
   logic [REQ_TDATA_W-1:0] in_ff;
   logic [REQ_TUSER_W-1:0] inu_ff;

   // body state
   logic signed [31:0] pvx_ff[2], pvy_ff[2], cvx_ff[2], cvy_ff[2];
   logic        [30:0] im_ff[2];
   logic         [1:0] kind_ff[2];
   logic signed [31:0] shx_ff[2], shy_ff[2];

   // work registers
   logic signed [31:0] wx_ff, wy_ff, t0_ff, t1_ff, acc_ff, j_ff;

   // divider
   logic          div_busy_ff, div_neg_ff, div_zero_ff;
   logic [31:0]   div_rem_ff, div_den_ff;
   logic [DW-1:0] div_quo_ff;
   logic [CNT_W-1:0] div_cnt_ff;

   logic [RSP_TDATA_W-1:0] out_ff;
   logic                   which_ff;

   logic signed [31:0] nx, ny;
   logic        [30:0] depth;
   logic               bsel;
   logic signed [32:0] ma, mb;
   logic signed [31:0] prod;
   logic signed [31:0] vsel_x, vsel_y;
   logic        [31:0] den;
   logic        [31:0] mag;
   logic        [32:0] shifted, trial;

   function automatic logic signed [31:0] fmul(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
      logic signed [65:0] p;
      p = a * b;
      p = p >>> FRACTION_BITS;
      return sat32(p);
   endfunction

   function automatic logic [30:0] im_eff(input logic [1:0] k, input logic [30:0] m);
      return k[0] ? 31'd0 : m;
   endfunction

   assign nx    = in_ff[REQ_NX +: 32];
   assign ny    = in_ff[REQ_NY +: 32];
   assign depth = in_ff[REQ_DEP +: 31];
   assign bsel  = cmd.body;

   assign vsel_x = cmd.vec ? cvx_ff[bsel] : pvx_ff[bsel];
   assign vsel_y = cmd.vec ? cvy_ff[bsel] : pvy_ff[bsel];
   assign den = {1'b0, im_eff(kind_ff[0], im_ff[0])} + {1'b0, im_eff(kind_ff[1], im_ff[1])};
   assign mag = acc_ff[31] ? 32'(-acc_ff) : acc_ff;
   assign shifted = {div_rem_ff, div_quo_ff[DW-1]};
   assign trial = shifted - {1'b0, div_den_ff};

   // select multiplier operands
   always_comb begin
      ma = s33(nx);
      mb = s33(acc_ff);
      case (cmd.op)
         OP_DOTX: begin ma = s33(wx_ff); mb = s33(nx); end
         OP_DOTY: begin ma = s33(wy_ff); mb = s33(ny); end
         OP_CANY, OP_SHY: begin ma = s33(ny); mb = s33(acc_ff); end
         OP_AMT:  begin ma = {2'b00, depth}; mb = {16'd0, cfg.share}; end
         OP_NUM:  begin ma = FX_ONE + {16'd0, cfg.restitution}; mb = s33(acc_ff); end
         OP_IX1:  begin ma = s33(nx); mb = s33(j_ff); end
         OP_IY1:  begin ma = s33(ny); mb = s33(j_ff); end
         OP_IX2:  begin ma = s33(t0_ff); mb = {2'b00, im_ff[bsel]}; end
         OP_IY2:  begin ma = s33(t1_ff); mb = {2'b00, im_ff[bsel]}; end
         default: begin ma = s33(nx); mb = s33(acc_ff); end
      endcase
   end

   assign prod = fmul(ma, mb);

   // capture the input beat
   always_ff @(posedge clock) begin
      if (take) begin
         in_ff  <= req_tdata;
         inu_ff <= req_tuser;
      end
   end

   // body state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            pvx_ff[i]  <= '0;
            pvy_ff[i]  <= '0;
            cvx_ff[i]  <= '0;
            cvy_ff[i]  <= '0;
            im_ff[i]   <= '0;
            kind_ff[i] <= '0;
            shx_ff[i]  <= '0;
            shy_ff[i]  <= '0;
         end
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               pvx_ff[inu_ff[1]]  <= in_ff[REQ_PVX +: 32];
               pvy_ff[inu_ff[1]]  <= in_ff[REQ_PVY +: 32];
               cvx_ff[inu_ff[1]]  <= in_ff[REQ_CVX +: 32];
               cvy_ff[inu_ff[1]]  <= in_ff[REQ_CVY +: 32];
               im_ff[inu_ff[1]]   <= in_ff[REQ_IM +: 31];
               kind_ff[inu_ff[1]] <= in_ff[REQ_KND +: 2];
            end
            OP_REL: begin
               for (int i = 0; i < 2; i++) begin
                  shx_ff[i] <= '0;
                  shy_ff[i] <= '0;
               end
            end
            OP_CANW: begin
               if (acc_ff < 0) begin
                  if (cmd.vec) begin
                     cvx_ff[bsel] <= sat32(sext(wx_ff) - sext(t0_ff));
                     cvy_ff[bsel] <= sat32(sext(wy_ff) - sext(t1_ff));
                  end else begin
                     pvx_ff[bsel] <= sat32(sext(wx_ff) - sext(t0_ff));
                     pvy_ff[bsel] <= sat32(sext(wy_ff) - sext(t1_ff));
                  end
               end
            end
            OP_SHW: begin
               if (!bsel) begin
                  shx_ff[bsel] <= t0_ff;
                  shy_ff[bsel] <= t1_ff;
               end else begin
                  shx_ff[bsel] <= sat32(-sext(t0_ff));
                  shy_ff[bsel] <= sat32(-sext(t1_ff));
               end
            end
            OP_IW: begin
               if (!bsel) begin
                  pvx_ff[bsel] <= sat32(sext(pvx_ff[bsel]) + sext(t0_ff));
                  pvy_ff[bsel] <= sat32(sext(pvy_ff[bsel]) + sext(t1_ff));
               end else begin
                  pvx_ff[bsel] <= sat32(sext(pvx_ff[bsel]) - sext(t0_ff));
                  pvy_ff[bsel] <= sat32(sext(pvy_ff[bsel]) - sext(t1_ff));
               end
            end
            default: ;
         endcase
      end
   end

   // work registers, no reset needed
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_REL: begin
            wx_ff <= sat32(sext(sat32(sext(pvx_ff[0]) + sext(cvx_ff[0])))
                         - sext(sat32(sext(pvx_ff[1]) + sext(cvx_ff[1]))));
            wy_ff <= sat32(sext(sat32(sext(pvy_ff[0]) + sext(cvy_ff[0])))
                         - sext(sat32(sext(pvy_ff[1]) + sext(cvy_ff[1]))));
         end
         OP_LDW: begin
            wx_ff <= vsel_x;
            wy_ff <= vsel_y;
         end
         OP_DOTX, OP_CANX, OP_SHX, OP_IX1, OP_IX2: t0_ff <= prod;
         OP_DOTY, OP_CANY, OP_SHY, OP_IY1, OP_IY2: t1_ff <= prod;
         OP_DOTSUM: acc_ff <= sat32(sext(t0_ff) + sext(t1_ff));
         OP_AMT: acc_ff <= prod;
         OP_NUM: acc_ff <= sat32(-sext(prod));
         OP_JSAT: begin
            if (div_zero_ff) j_ff <= '0;
            else if (div_neg_ff) begin
               if (div_quo_ff >= DW'(64'h80000000)) j_ff <= 32'sh80000000;
               else j_ff <= 32'(-div_quo_ff[31:0]);
            end else begin
               if (div_quo_ff > DW'(64'h7FFFFFFF)) j_ff <= 32'sh7FFFFFFF;
               else j_ff <= div_quo_ff[31:0];
            end
         end
         default: ;
      endcase
   end

   // restoring divider, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cmd.op == OP_DIVGO) begin
         div_busy_ff <= (den != 32'd0);
         div_cnt_ff  <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         if (div_cnt_ff == CNT_W'(DW - 1)) div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DIVGO) begin
         div_zero_ff <= (den == 32'd0);
         div_neg_ff  <= acc_ff[31];
         div_den_ff  <= den;
         div_rem_ff  <= '0;
         div_quo_ff  <= {mag, {FRACTION_BITS{1'b0}}};
      end else if (div_busy_ff) begin
         if (!trial[32]) begin
            div_rem_ff <= trial[31:0];
            div_quo_ff <= {div_quo_ff[DW-2:0], 1'b1};
         end else begin
            div_rem_ff <= shifted[31:0];
            div_quo_ff <= {div_quo_ff[DW-2:0], 1'b0};
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT) begin
         out_ff   <= {shy_ff[bsel], shx_ff[bsel], cvy_ff[bsel], cvx_ff[bsel],
                      pvy_ff[bsel], pvx_ff[bsel]};
         which_ff <= bsel;
      end
   end

   assign rsp_tdata = out_ff;
   assign rsp_tuser = which_ff;
   assign rsp_tlast = which_ff;

   assign status.is_load  = (inu_ff[0] == CMD_LOAD);
   assign status.coll     = in_ff[REQ_COL];
   assign status.acc_pos  = (acc_ff > 0);
   assign status.fixd     = {kind_ff[1][0], kind_ff[0][0]};
   assign status.kin      = {kind_ff[1][1], kind_ff[0][1]};
   assign status.div_busy = div_busy_ff;
endmodule

@@ rtl/impulse_collision_response.sv @@
// Two-body impulse collision response, Q(32-F).F fixed point.
// A load, or a resolve without collision or with bodies separating, gives no result;
// kinematic-against-fixed and impulse resolves (the impulse through the serial divider)
// return body A then body B, each result held until it is taken.
// One item at a time. Synchronous active-high reset clears body state to
// zero and loads the default restitution and correction share.
module impulse_collision_response
   import impc_pkg::*;
#(
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // phys_vel_x, phys_vel_y, ctrl_vel_x, ctrl_vel_y, inv_mass, body_kind,
   // collided, normal_x, normal_y, depth, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command, body_select
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // new_phys_vel_x, new_phys_vel_y, new_ctrl_vel_x, new_ctrl_vel_y,
   // shift_x, shift_y
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // which_body
   output logic                   rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       take;

   assign take = req_tvalid & req_tready;

   impc_csr #(.FRACTION_BITS(FRACTION_BITS)) u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   impc_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .status, .cmd
   );

   impc_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock, .reset, .take, .req_tdata, .req_tuser, .cfg, .cmd, .status,
      .rsp_tdata, .rsp_tuser, .rsp_tlast
   );
endmodule
